// ===== rtl/tiru_pkg.sv =====
// Shared types and constants of the trap, interrupt and return unit.
package tiru_pkg;

   localparam int XLEN      = 64;
   localparam int CSR_AW    = 6;
   localparam int IRQ_COUNT = 6;

   // Command codes.
   localparam logic [2:0] CMD_EXCEPTION = 3'd0;
   localparam logic [2:0] CMD_IRQ_CHECK = 3'd1;
   localparam logic [2:0] CMD_MRET      = 3'd2;
   localparam logic [2:0] CMD_SRET      = 3'd3;
   localparam logic [2:0] CMD_LINES     = 3'd4;

   // Configuration register indexes (byte address is 8 times the index).
   localparam logic [2:0] REG_MEDELEG  = 3'd0;
   localparam logic [2:0] REG_MIDELEG  = 3'd1;
   localparam logic [2:0] REG_MTVEC    = 3'd2;
   localparam logic [2:0] REG_STVEC    = 3'd3;
   localparam logic [2:0] REG_MIE      = 3'd4;
   localparam logic [2:0] REG_STIMECMP = 3'd5;
   localparam logic [2:0] REG_MISA_C   = 3'd6;

   // Privilege levels.
   localparam logic [1:0] PRIV_U = 2'd0;
   localparam logic [1:0] PRIV_S = 2'd1;
   localparam logic [1:0] PRIV_M = 2'd3;

   // mstatus bit positions.
   localparam int ST_SIE    = 1;
   localparam int ST_MIE    = 3;
   localparam int ST_SPIE   = 5;
   localparam int ST_MPIE   = 7;
   localparam int ST_SPP    = 8;
   localparam int ST_MPP_LO = 11;
   localparam int ST_MPP_HI = 12;
   localparam int ST_MPRV   = 17;

   localparam int STIP_LINE = 5;
   localparam logic [1:0] TVEC_VECTORED = 2'd1;

   // Interrupt ids from highest to lowest priority: MEI, MSI, MTI, SEI, SSI, STI.
   localparam logic [5:0] IRQ_RANK [IRQ_COUNT] = '{6'd11, 6'd3, 6'd7, 6'd9, 6'd1, 6'd5};

   typedef struct packed {
      logic [2:0]      command;
      logic [XLEN-1:0] current_pc;
      logic [5:0]      cause_code;
      logic [XLEN-1:0] trap_value;
      logic [XLEN-1:0] line_mask;
      logic            line_level;
      logic            timer_present;
      logic [XLEN-1:0] timer_now;
      logic [XLEN-1:0] software_pending;
   } req_type;

   typedef struct packed {
      logic            redirect;
      logic [XLEN-1:0] target_pc;
      logic [1:0]      privilege;
      logic [XLEN-1:0] machine_status;
      logic [XLEN-1:0] cause_taken;
   } rsp_type;

   typedef struct packed {
      logic [XLEN-1:0] medeleg;
      logic [XLEN-1:0] mideleg;
      logic [XLEN-1:0] mtvec;
      logic [XLEN-1:0] stvec;
      logic [XLEN-1:0] mie;
      logic [XLEN-1:0] stimecmp;
      logic            compressed;
   } cfg_type;

endpackage

// ===== rtl/tiru_csr.sv =====
// Configuration register bank with its APB-style access port.
module tiru_csr
   import tiru_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [XLEN-1:0]   csr_pwdata,
   output logic [XLEN-1:0]   csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic       write_en;
   logic [2:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_AW-1:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.medeleg    <= '0;
         cfg_ff.mideleg    <= '0;
         cfg_ff.mtvec      <= '0;
         cfg_ff.stvec      <= '0;
         cfg_ff.mie        <= '0;
         cfg_ff.stimecmp   <= '1;
         cfg_ff.compressed <= 1'b1;
      end else if (write_en) begin
         unique case (reg_index)
            REG_MEDELEG:  cfg_ff.medeleg    <= csr_pwdata;
            REG_MIDELEG:  cfg_ff.mideleg    <= csr_pwdata;
            REG_MTVEC:    cfg_ff.mtvec      <= csr_pwdata;
            REG_STVEC:    cfg_ff.stvec      <= csr_pwdata;
            REG_MIE:      cfg_ff.mie        <= csr_pwdata;
            REG_STIMECMP: cfg_ff.stimecmp   <= csr_pwdata;
            REG_MISA_C:   cfg_ff.compressed <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MEDELEG:  csr_prdata = cfg_ff.medeleg;
         REG_MIDELEG:  csr_prdata = cfg_ff.mideleg;
         REG_MTVEC:    csr_prdata = cfg_ff.mtvec;
         REG_STVEC:    csr_prdata = cfg_ff.stvec;
         REG_MIE:      csr_prdata = cfg_ff.mie;
         REG_STIMECMP: csr_prdata = cfg_ff.stimecmp;
         REG_MISA_C:   csr_prdata = {{(XLEN-1){1'b0}}, cfg_ff.compressed};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tiru_core.sv =====
// Privilege state, trap and return logic between the request and result registers.
module tiru_core
   import tiru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Request register and result register.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    accept, advance;

   // Architectural state.
   logic [XLEN-1:0] status_ff, status_in;
   logic [1:0]      priv_ff, priv_in;
   logic [XLEN-1:0] mepc_ff, mepc_in, mcause_ff, mcause_in, mtval_ff, mtval_in;
   logic [XLEN-1:0] sepc_ff, sepc_in, scause_ff, scause_in, stval_ff, stval_in;
   logic [XLEN-1:0] lines_ff, lines_in;

   // Working signals.
   logic [XLEN-1:0]      lines_tick, pending, deleg, tvec, vector, ret_pc, ret_epc;
   logic [IRQ_COUNT-1:0] take_vec;
   logic                 irq_found;
   logic [5:0]           irq_id;
   logic                 trap_go, is_int, to_s;
   logic [XLEN-1:0]      trap_cause, trap_tval;
   logic [1:0]           mpp;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Timer compare and interrupt selection.
   always_comb begin
      lines_tick = lines_ff;
      if (in_data_ff.timer_present && (cfg.stimecmp != '1)) begin
         lines_tick[STIP_LINE] = (in_data_ff.timer_now >= cfg.stimecmp);
      end
      pending = (in_data_ff.software_pending | lines_tick) & cfg.mie;
      for (int i = 0; i < IRQ_COUNT; i++) begin
         if (cfg.mideleg[IRQ_RANK[i]]) begin
            take_vec[i] = pending[IRQ_RANK[i]] &&
                          ((priv_ff == PRIV_S) ? status_ff[ST_SIE] : (priv_ff == PRIV_U));
         end else begin
            take_vec[i] = pending[IRQ_RANK[i]] &&
                          ((priv_ff == PRIV_M) ? status_ff[ST_MIE] : 1'b1);
         end
      end
      // Walk from lowest to highest priority so the highest taken one wins.
      irq_found = 1'b0;
      irq_id    = '0;
      for (int i = IRQ_COUNT - 1; i >= 0; i--) begin
         if (take_vec[i]) begin
            irq_found = 1'b1;
            irq_id    = IRQ_RANK[i];
         end
      end
   end

   // Command execution.
   always_comb begin
      status_in  = status_ff;
      priv_in    = priv_ff;
      mepc_in    = mepc_ff;
      mcause_in  = mcause_ff;
      mtval_in   = mtval_ff;
      sepc_in    = sepc_ff;
      scause_in  = scause_ff;
      stval_in   = stval_ff;
      lines_in   = lines_ff;
      trap_go    = 1'b0;
      trap_cause = '0;
      trap_tval  = '0;
      ret_epc    = '0;
      mpp        = status_ff[ST_MPP_HI:ST_MPP_LO];
      out_data_in.redirect  = 1'b0;
      out_data_in.target_pc = '0;

      case (in_data_ff.command)
         CMD_EXCEPTION: begin
            trap_go    = 1'b1;
            trap_cause = {{(XLEN-6){1'b0}}, in_data_ff.cause_code};
            trap_tval  = in_data_ff.trap_value;
         end
         CMD_IRQ_CHECK: begin
            lines_in = lines_tick;
            if (irq_found) begin
               trap_go    = 1'b1;
               trap_cause = {1'b1, {(XLEN-7){1'b0}}, irq_id};
            end
         end
         CMD_MRET: begin
            status_in[ST_MIE]  = status_ff[ST_MPIE];
            status_in[ST_MPIE] = 1'b1;
            if (mpp != PRIV_M) begin
               status_in[ST_MPRV] = 1'b0;
            end
            status_in[ST_MPP_HI:ST_MPP_LO] = PRIV_U;
            priv_in = mpp;
            ret_epc = mepc_ff;
            out_data_in.redirect = 1'b1;
         end
         CMD_SRET: begin
            status_in[ST_SIE]  = status_ff[ST_SPIE];
            status_in[ST_SPIE] = 1'b1;
            status_in[ST_MPRV] = 1'b0;
            status_in[ST_SPP]  = 1'b0;
            priv_in = status_ff[ST_SPP] ? PRIV_S : PRIV_U;
            ret_epc = sepc_ff;
            out_data_in.redirect = 1'b1;
         end
         CMD_LINES: begin
            if (in_data_ff.line_level) begin
               lines_in = lines_ff | in_data_ff.line_mask;
            end else begin
               lines_in = lines_ff & ~in_data_ff.line_mask;
            end
         end
         default: ;
      endcase

      // Return address: bit 0 always clear, bit 1 kept only with compressed code.
      ret_pc    = ret_epc;
      ret_pc[0] = 1'b0;
      if (!cfg.compressed) begin
         ret_pc[1] = 1'b0;
      end
      if (out_data_in.redirect) begin
         out_data_in.target_pc = ret_pc;
      end

      is_int = trap_cause[XLEN-1];
      deleg  = is_int ? cfg.mideleg : cfg.medeleg;
      to_s   = deleg[trap_cause[5:0]] && (priv_ff != PRIV_M);
      tvec   = to_s ? cfg.stvec : cfg.mtvec;
      vector = {tvec[XLEN-1:2], 2'b00};
      if ((tvec[1:0] == TVEC_VECTORED) && is_int) begin
         vector = vector + {{(XLEN-6){1'b0}}, trap_cause[3:0], 2'b00};
      end

      if (trap_go) begin
         if (to_s) begin
            sepc_in            = in_data_ff.current_pc;
            scause_in          = trap_cause;
            stval_in           = trap_tval;
            status_in[ST_SPIE] = status_ff[ST_SIE];
            status_in[ST_SIE]  = 1'b0;
            status_in[ST_SPP]  = (priv_ff == PRIV_S);
            priv_in            = PRIV_S;
         end else begin
            mepc_in            = in_data_ff.current_pc;
            mcause_in          = trap_cause;
            mtval_in           = trap_tval;
            status_in[ST_MPIE] = status_ff[ST_MIE];
            status_in[ST_MIE]  = 1'b0;
            status_in[ST_MPP_HI:ST_MPP_LO] = priv_ff;
            priv_in            = PRIV_M;
         end
         out_data_in.redirect  = 1'b1;
         out_data_in.target_pc = vector;
      end

      out_data_in.privilege      = priv_in;
      out_data_in.machine_status = status_in;
      out_data_in.cause_taken    = trap_go ? trap_cause : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff    <= '0;
         priv_ff      <= PRIV_M;
         mepc_ff      <= '0;
         mcause_ff    <= '0;
         mtval_ff     <= '0;
         sepc_ff      <= '0;
         scause_ff    <= '0;
         stval_ff     <= '0;
         lines_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            status_ff <= status_in;
            priv_ff   <= priv_in;
            mepc_ff   <= mepc_in;
            mcause_ff <= mcause_in;
            mtval_ff  <= mtval_in;
            sepc_ff   <= sepc_in;
            scause_ff <= scause_in;
            stval_ff  <= stval_in;
            lines_ff  <= lines_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_priv_legal: assert property (@(posedge clock) disable iff (reset)
      priv_ff != 2'd2)
      else $error("privilege register holds the reserved level");

   a_no_redirect_no_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.redirect) |-> (rsp_data.target_pc == '0))
      else $error("target pc is nonzero without a redirect");

   a_no_redirect_no_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.redirect) |-> (rsp_data.cause_taken == '0))
      else $error("cause reported without a redirect");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request advanced but no result is held");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request side stalled without a blocked item");
`endif

endmodule

// ===== rtl/trap_interrupt_return_unit.sv =====
// Top level of the RV64 trap, interrupt and return unit.
//
// The req_ channel carries one command per request: take an exception,
// check for and take a pending interrupt, mret, sret, or set/clear the
// external interrupt lines. Each request yields exactly one result on the
// rsp_ channel with the redirect flag, target pc, new privilege, mstatus
// and the cause taken.
// A request that is accepted is held in the request register; its result is
// computed from that register and lands in the result register when it can
// advance, and rsp_valid then shows it to the receiver. One request per cycle
// is sustained while the receiver does not stall; the two registers and the
// combinational state update between them set that rate.
// While the receiver stalls, the result register holds, the request register
// can still take one more request, and then req_stall rises.
// The csr_ port writes the delegation, vector, enable, timer compare and
// compressed-enable registers at byte addresses 8 times the index.
// Reset brings up machine mode, mstatus zero, all epc/cause/tval and lines
// zero, timer compare all ones and compressed enabled, with both channels empty.
module trap_interrupt_return_unit
   import tiru_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [XLEN-1:0]   csr_pwdata,
   output logic [XLEN-1:0]   csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   tiru_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tiru_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
